>>> rtl/fsiac_pkg.sv
// Shared types, codes and scaling helpers for the alarm panel controller.
// Used by fsiac_cfg, fsiac_step and fire_smoke_intrusion_alarm_control.
`default_nettype none

package fsiac_pkg;

  // Event kinds; code three acts as a poll
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_PULSE = 2'd1;
  localparam logic [1:0] FUNC_POLL  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOKE_ON  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOKE_OFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS     = 3'd5;

  // Register reset values
  localparam logic [8:0] FIRE_ON_RST   = 9'd60;
  localparam logic [8:0] FIRE_OFF_RST  = 9'd30;
  localparam logic [6:0] SMOKE_ON_RST  = 7'd60;
  localparam logic [6:0] SMOKE_OFF_RST = 7'd30;
  localparam logic [3:0] PULSES_RST    = 4'd10;
  localparam logic [3:0] TICKS_RST     = 4'd6;

  // Bit positions inside the output latch word
  localparam int unsigned NUM_LATCH  = 10;
  localparam int unsigned B_ALARM    = 0;
  localparam int unsigned B_LIGHT    = 1;
  localparam int unsigned B_EXHAUST  = 2;
  localparam int unsigned B_EMERG    = 3;
  localparam int unsigned B_SIREN    = 4;
  localparam int unsigned B_NORMAL   = 5;
  localparam int unsigned B_INTRUDER = 6;
  localparam int unsigned B_FIRELED  = 7;
  localparam int unsigned B_SMOKELED = 8;
  localparam int unsigned B_GUARDLED = 9;

  // Reciprocal constants: floor(adc*500/255) and floor(adc*100/255)
  // are exact for every 8-bit reading as (adc*K) >> 16.
  localparam logic [16:0] TEMP_RECIP  = 17'd128502;
  localparam logic [14:0] SMOKE_RECIP = 15'd25701;

  typedef struct packed {
    logic [8:0] fire_on_level;
    logic [8:0] fire_off_level;
    logic [6:0] smoke_on_level;
    logic [6:0] smoke_off_level;
    logic [3:0] pulses_to_trip;
    logic [3:0] ticks_per_sample;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic       disarm_held;
    logic       guard_off;
    logic [7:0] temp_sample;
    logic [7:0] smoke_sample;
  } item_t;

  typedef struct packed {
    logic [3:0]           pulse_count;
    logic [3:0]           tick_count;
    logic                 fire_active;
    logic                 smoke_active;
    logic                 intrusion_active;
    logic                 sample_pending;
    logic                 sampler_running;
    logic [NUM_LATCH-1:0] latches;
    logic [8:0]           temp_latched;
    logic [6:0]           smoke_latched;
  } state_t;

  // Temperature reading to 0..500
  function automatic logic [8:0] scale_temp(input logic [7:0] adc);
    logic [24:0] prod;
    prod = 25'(adc) * 25'(TEMP_RECIP);
    return prod[24:16];
  endfunction

  // Smoke reading to 0..100 percent
  function automatic logic [6:0] scale_smoke(input logic [7:0] adc);
    logic [22:0] prod;
    prod = 23'(adc) * 23'(SMOKE_RECIP);
    return prod[22:16];
  endfunction

endpackage

`default_nettype wire

>>> rtl/fire_smoke_intrusion_alarm_control.sv
// Top level of the alarm panel controller: input register, panel state
// register (which also serves as the result register) and handshakes.
// Depends on fsiac_pkg, fsiac_cfg and fsiac_step.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    func, disarm_held, guard_off, temp_sample,
//                                   smoke_sample
//   out      out_valid / out_ready  alarm_out .. guard_led, temperature_shown,
//                                   smoke_shown
//   cfg      cfg_we                 cfg_index, cfg_data
//
// One event per cycle sustained while results are taken; out_valid rises once
// the event has passed the input register and then the event logic into the
// state register.
// The critical path is one 8x17 constant multiply plus a threshold compare.
// Reset (synchronous, rst high) empties both stages and restores defaults.
// A stalled result holds the state register; one more event waits in the
// input register, and in_ready drops only when both are occupied.
`default_nettype none

module fire_smoke_intrusion_alarm_control (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Event channel
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [1:0]                      func,
  input  wire logic                            disarm_held,
  input  wire logic                            guard_off,
  input  wire logic [7:0]                      temp_sample,
  input  wire logic [7:0]                      smoke_sample,
  // Result channel
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic                            alarm_out,
  output      logic                            light_out,
  output      logic                            exhaust_out,
  output      logic                            emergency_out,
  output      logic                            siren_out,
  output      logic                            normal_led,
  output      logic                            intruder_led,
  output      logic                            fire_led,
  output      logic                            smoke_led,
  output      logic                            guard_led,
  output      logic [8:0]                      temperature_shown,
  output      logic [6:0]                      smoke_shown,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [fsiac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fsiac_pkg::CFG_DATA_W-1:0] cfg_data
);

  fsiac_pkg::cfg_t   cfg;
  fsiac_pkg::item_t  item;
  fsiac_pkg::state_t st;
  fsiac_pkg::state_t st_next;
  logic              item_valid;
  logic              advance;

  fsiac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fsiac_step u_step (
    .cfg     (cfg),
    .item    (item),
    .st      (st),
    .st_next (st_next)
  );

  // Move the held event into the state when the result slot is free
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.func         <= func;
      item.disarm_held  <= disarm_held;
      item.guard_off    <= guard_off;
      item.temp_sample  <= temp_sample;
      item.smoke_sample <= smoke_sample;
    end
  end

  // Panel state; its latches and shown values are the result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      st.pulse_count      <= 4'd0;
      st.tick_count       <= 4'd0;
      st.fire_active      <= 1'b0;
      st.smoke_active     <= 1'b0;
      st.intrusion_active <= 1'b0;
      st.sample_pending   <= 1'b1;
      st.sampler_running  <= 1'b0;
      st.latches          <= '0;
      st.temp_latched     <= 9'd0;
      st.smoke_latched    <= 7'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result valid: set on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign alarm_out         = st.latches[fsiac_pkg::B_ALARM];
  assign light_out         = st.latches[fsiac_pkg::B_LIGHT];
  assign exhaust_out       = st.latches[fsiac_pkg::B_EXHAUST];
  assign emergency_out     = st.latches[fsiac_pkg::B_EMERG];
  assign siren_out         = st.latches[fsiac_pkg::B_SIREN];
  assign normal_led        = st.latches[fsiac_pkg::B_NORMAL];
  assign intruder_led      = st.latches[fsiac_pkg::B_INTRUDER];
  assign fire_led          = st.latches[fsiac_pkg::B_FIRELED];
  assign smoke_led         = st.latches[fsiac_pkg::B_SMOKELED];
  assign guard_led         = st.latches[fsiac_pkg::B_GUARDLED];
  assign temperature_shown = st.temp_latched;
  assign smoke_shown       = st.smoke_latched;

`ifndef SYNTH
  // A pending sample is always taken in the same event that sets it by tick
  a_pending_not_running: assert property (@(posedge clk) disable iff (rst)
    !(st.sample_pending && st.sampler_running))
    else $error("sample pending while sampler running");

  // Actuators track the condition flags
  a_actuators_track: assert property (@(posedge clk) disable iff (rst)
    (emergency_out == st.fire_active) && (siren_out == st.fire_active) &&
    (exhaust_out == st.smoke_active))
    else $error("actuator latch out of step with condition flag");

  // Disarm clears all latches and fire/smoke flags
  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.disarm_held |=>
      (st.latches == '0) && !st.fire_active && !st.smoke_active)
    else $error("disarm did not clear the panel");

  // Normal LED never lit with intrusion latched
  a_normal_no_intrusion: assert property (@(posedge clk) disable iff (rst)
    normal_led |-> !st.intrusion_active)
    else $error("normal LED lit during intrusion");

  // Input stalls only with both stages full and the result not taken
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (item_valid && out_valid && !out_ready))
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

>>> rtl/fsiac_cfg.sv
// Configuration register file for the alarm panel controller.
// Depends on fsiac_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module fsiac_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [fsiac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsiac_pkg::CFG_DATA_W-1:0] cfg_data,
  output fsiac_pkg::cfg_t                     cfg
);

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fire_on_level    <= fsiac_pkg::FIRE_ON_RST;
      cfg.fire_off_level   <= fsiac_pkg::FIRE_OFF_RST;
      cfg.smoke_on_level   <= fsiac_pkg::SMOKE_ON_RST;
      cfg.smoke_off_level  <= fsiac_pkg::SMOKE_OFF_RST;
      cfg.pulses_to_trip   <= fsiac_pkg::PULSES_RST;
      cfg.ticks_per_sample <= fsiac_pkg::TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsiac_pkg::REG_FIRE_ON:   cfg.fire_on_level    <= cfg_data;
        fsiac_pkg::REG_FIRE_OFF:  cfg.fire_off_level   <= cfg_data;
        fsiac_pkg::REG_SMOKE_ON:  cfg.smoke_on_level   <= cfg_data[6:0];
        fsiac_pkg::REG_SMOKE_OFF: cfg.smoke_off_level  <= cfg_data[6:0];
        fsiac_pkg::REG_PULSES:    cfg.pulses_to_trip   <= cfg_data[3:0];
        fsiac_pkg::REG_TICKS:     cfg.ticks_per_sample <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fsiac_step.sv
// Next-state logic for one panel event: pulses, ticks, sampling with
// hysteresis, status LEDs and guard handling. Depends on fsiac_pkg.
`default_nettype none

module fsiac_step (
  input  wire fsiac_pkg::cfg_t   cfg,
  input  wire fsiac_pkg::item_t  item,
  input  wire fsiac_pkg::state_t st,
  output fsiac_pkg::state_t      st_next
);

  // Refresh status LEDs from the condition flags
  function automatic logic [fsiac_pkg::NUM_LATCH-1:0] status_leds(
    input logic [fsiac_pkg::NUM_LATCH-1:0] l_in,
    input logic fire,
    input logic smoke,
    input logic intr
  );
    logic [fsiac_pkg::NUM_LATCH-1:0] l;
    l = l_in;
    if (!fire && !smoke && !intr) begin
      l[fsiac_pkg::B_NORMAL]   = 1'b1;
      l[fsiac_pkg::B_SMOKELED] = 1'b0;
      l[fsiac_pkg::B_FIRELED]  = 1'b0;
    end
    if (smoke && !fire) begin
      l[fsiac_pkg::B_SMOKELED] = 1'b1;
      l[fsiac_pkg::B_NORMAL]   = 1'b0;
      l[fsiac_pkg::B_FIRELED]  = 1'b0;
    end
    if (fire && !smoke) begin
      l[fsiac_pkg::B_FIRELED]  = 1'b1;
      l[fsiac_pkg::B_NORMAL]   = 1'b0;
      l[fsiac_pkg::B_SMOKELED] = 1'b0;
    end
    if (fire && smoke) begin
      l[fsiac_pkg::B_FIRELED]  = 1'b1;
      l[fsiac_pkg::B_SMOKELED] = 1'b1;
      l[fsiac_pkg::B_NORMAL]   = 1'b0;
    end
    if (intr) begin
      l[fsiac_pkg::B_INTRUDER] = 1'b1;
      l[fsiac_pkg::B_NORMAL]   = 1'b0;
      l[fsiac_pkg::B_SMOKELED] = 1'b0;
    end
    return l;
  endfunction

  logic [3:0] pulse_lim;
  logic [3:0] tick_lim;
  logic [3:0] pulse_inc;
  logic [3:0] tick_inc;
  logic [8:0] temp_scaled;
  logic [6:0] smoke_scaled;

  // Zero limits behave as one
  assign pulse_lim = (cfg.pulses_to_trip == 4'd0) ? 4'd1 : cfg.pulses_to_trip;
  assign tick_lim  = (cfg.ticks_per_sample == 4'd0) ? 4'd1 : cfg.ticks_per_sample;
  assign pulse_inc = 4'(st.pulse_count + 4'd1);
  assign tick_inc  = 4'(st.tick_count + 4'd1);

  assign temp_scaled  = fsiac_pkg::scale_temp(item.temp_sample);
  assign smoke_scaled = fsiac_pkg::scale_smoke(item.smoke_sample);

  always_comb begin
    st_next = st;
    if (item.disarm_held) begin
      // Disarm: reinitialize, keep intrusion, counters and shown values
      st_next.sample_pending  = 1'b1;
      st_next.sampler_running = 1'b0;
      st_next.latches         = '0;
      st_next.fire_active     = 1'b0;
      st_next.smoke_active    = 1'b0;
    end else begin
      // Intrusion pulse or timer tick
      if (item.func == fsiac_pkg::FUNC_PULSE && !item.guard_off && !st.intrusion_active) begin
        st_next.pulse_count = pulse_inc;
        if (pulse_inc >= pulse_lim) begin
          st_next.latches[fsiac_pkg::B_ALARM] = 1'b1;
          st_next.latches[fsiac_pkg::B_LIGHT] = 1'b1;
          st_next.intrusion_active = 1'b1;
          st_next.pulse_count      = 4'd0;
          st_next.latches = status_leds(st_next.latches, st_next.fire_active,
                                        st_next.smoke_active, 1'b1);
        end
      end else if (item.func == fsiac_pkg::FUNC_TICK && st.sampler_running) begin
        st_next.tick_count = tick_inc;
        if (tick_inc >= tick_lim) begin
          st_next.sample_pending = 1'b1;
          st_next.tick_count     = 4'd0;
        end
      end

      // Pending sample with on/off hysteresis
      if (st_next.sample_pending) begin
        st_next.sample_pending  = 1'b0;
        st_next.sampler_running = 1'b1;
        st_next.temp_latched    = temp_scaled;
        st_next.smoke_latched   = smoke_scaled;
        if (temp_scaled > cfg.fire_on_level && !st_next.fire_active) begin
          st_next.fire_active = 1'b1;
          st_next.latches[fsiac_pkg::B_ALARM] = 1'b1;
          st_next.latches[fsiac_pkg::B_EMERG] = 1'b1;
          st_next.latches[fsiac_pkg::B_SIREN] = 1'b1;
        end
        if (temp_scaled < cfg.fire_off_level && st_next.fire_active) begin
          st_next.fire_active = 1'b0;
          st_next.latches[fsiac_pkg::B_ALARM] = 1'b0;
          st_next.latches[fsiac_pkg::B_EMERG] = 1'b0;
          st_next.latches[fsiac_pkg::B_SIREN] = 1'b0;
        end
        if (smoke_scaled > cfg.smoke_on_level && !st_next.smoke_active) begin
          st_next.smoke_active = 1'b1;
          st_next.latches[fsiac_pkg::B_EXHAUST] = 1'b1;
        end
        if (smoke_scaled < cfg.smoke_off_level && st_next.smoke_active) begin
          st_next.smoke_active = 1'b0;
          st_next.latches[fsiac_pkg::B_EXHAUST] = 1'b0;
        end
        st_next.latches = status_leds(st_next.latches, st_next.fire_active,
                                      st_next.smoke_active, st_next.intrusion_active);
      end

      // Guard switch: off with intrusion latched reinitializes the panel
      if (!item.guard_off) begin
        st_next.latches[fsiac_pkg::B_GUARDLED] = 1'b1;
      end else begin
        st_next.latches[fsiac_pkg::B_GUARDLED] = 1'b0;
        if (st_next.intrusion_active) begin
          st_next.sample_pending   = 1'b1;
          st_next.sampler_running  = 1'b0;
          st_next.latches          = '0;
          st_next.fire_active      = 1'b0;
          st_next.smoke_active     = 1'b0;
          st_next.intrusion_active = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/fire_smoke_intrusion_alarm_control_test.sv
// Self-checking testbench for the alarm panel controller: a directed table,
// then random event traffic under several threshold settings.
// Depends on fsiac_pkg and fire_smoke_intrusion_alarm_control.
`timescale 1ns / 1ps

module fire_smoke_intrusion_alarm_control_test;

  // Event code three has no name in the package; the panel treats it as a poll
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned ADC_FULL = 255;
  localparam int unsigned TEMP_FULL = 500;
  localparam int unsigned SMOKE_FULL = 100;
  localparam int unsigned EVENTS_PER_PHASE = 140;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned SCRIPT_LEN = 14;
  localparam int unsigned NUM_PLANS = 6;

  typedef logic [fsiac_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [fsiac_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [fsiac_pkg::NUM_LATCH-1:0] latches;
    logic [8:0]                      temp;
    logic [6:0]                      smoke;
  } panel_view_t;

  typedef struct {
    fsiac_pkg::item_t ev;
    int unsigned      reps;
    bit               typed;
    panel_view_t      want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready;
  logic [1:0] func;
  logic disarm_held, guard_off;
  logic [7:0] temp_sample, smoke_sample;
  logic out_valid, out_ready;
  logic alarm_out, light_out, exhaust_out, emergency_out, siren_out;
  logic normal_led, intruder_led, fire_led, smoke_led, guard_led;
  logic [8:0] temperature_shown;
  logic [6:0] smoke_shown;
  logic cfg_we;
  logic [fsiac_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fsiac_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor state and the thresholds it works with
  fsiac_pkg::state_t panel;
  fsiac_pkg::cfg_t levels_now;
  panel_view_t expected_views[$];
  script_row_t script [SCRIPT_LEN];
  int unsigned accepted_events = 0;
  int unsigned error_count = 0;
  bit calm = 1'b0;

  string latch_name [fsiac_pkg::NUM_LATCH] = '{"alarm_out", "light_out", "exhaust_out",
    "emergency_out", "siren_out", "normal_led", "intruder_led", "fire_led",
    "smoke_led", "guard_led"};

  fire_smoke_intrusion_alarm_control u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .disarm_held(disarm_held), .guard_off(guard_off),
    .temp_sample(temp_sample), .smoke_sample(smoke_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .alarm_out(alarm_out), .light_out(light_out), .exhaust_out(exhaust_out),
    .emergency_out(emergency_out), .siren_out(siren_out),
    .normal_led(normal_led), .intruder_led(intruder_led), .fire_led(fire_led),
    .smoke_led(smoke_led), .guard_led(guard_led),
    .temperature_shown(temperature_shown), .smoke_shown(smoke_shown),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void panel_reinit();
    panel.sample_pending = 1'b1;
    panel.sampler_running = 1'b0;
    panel.latches = '0;
    panel.fire_active = 1'b0;
    panel.smoke_active = 1'b0;
  endfunction

  // Status LEDs follow the fire, smoke and intrusion flags; later rules win
  function automatic void refresh_leds();
    logic f, s;
    f = panel.fire_active;
    s = panel.smoke_active;
    if (!f && !s && !panel.intrusion_active) begin
      panel.latches[fsiac_pkg::B_NORMAL] = 1'b1;
      panel.latches[fsiac_pkg::B_SMOKELED] = 1'b0;
      panel.latches[fsiac_pkg::B_FIRELED] = 1'b0;
    end
    if (s && !f) begin
      panel.latches[fsiac_pkg::B_SMOKELED] = 1'b1;
      panel.latches[fsiac_pkg::B_NORMAL] = 1'b0;
      panel.latches[fsiac_pkg::B_FIRELED] = 1'b0;
    end
    if (f && !s) begin
      panel.latches[fsiac_pkg::B_FIRELED] = 1'b1;
      panel.latches[fsiac_pkg::B_NORMAL] = 1'b0;
      panel.latches[fsiac_pkg::B_SMOKELED] = 1'b0;
    end
    if (f && s) begin
      panel.latches[fsiac_pkg::B_FIRELED] = 1'b1;
      panel.latches[fsiac_pkg::B_SMOKELED] = 1'b1;
      panel.latches[fsiac_pkg::B_NORMAL] = 1'b0;
    end
    if (panel.intrusion_active) begin
      panel.latches[fsiac_pkg::B_INTRUDER] = 1'b1;
      panel.latches[fsiac_pkg::B_NORMAL] = 1'b0;
      panel.latches[fsiac_pkg::B_SMOKELED] = 1'b0;
    end
  endfunction

  // Scale both readings, then apply the on test before the off test
  function automatic void sample_sensors(logic [7:0] t, logic [7:0] s);
    panel.temp_latched = 9'((32'(t) * TEMP_FULL) / ADC_FULL);
    panel.smoke_latched = 7'((32'(s) * SMOKE_FULL) / ADC_FULL);
    if (panel.temp_latched > levels_now.fire_on_level && !panel.fire_active) begin
      panel.fire_active = 1'b1;
      panel.latches[fsiac_pkg::B_ALARM] = 1'b1;
      panel.latches[fsiac_pkg::B_EMERG] = 1'b1;
      panel.latches[fsiac_pkg::B_SIREN] = 1'b1;
    end
    if (panel.temp_latched < levels_now.fire_off_level && panel.fire_active) begin
      panel.fire_active = 1'b0;
      panel.latches[fsiac_pkg::B_ALARM] = 1'b0;
      panel.latches[fsiac_pkg::B_EMERG] = 1'b0;
      panel.latches[fsiac_pkg::B_SIREN] = 1'b0;
    end
    if (panel.smoke_latched > levels_now.smoke_on_level && !panel.smoke_active) begin
      panel.smoke_active = 1'b1;
      panel.latches[fsiac_pkg::B_EXHAUST] = 1'b1;
    end
    if (panel.smoke_latched < levels_now.smoke_off_level && panel.smoke_active) begin
      panel.smoke_active = 1'b0;
      panel.latches[fsiac_pkg::B_EXHAUST] = 1'b0;
    end
    refresh_leds();
  endfunction

  // Advance the panel by one event and return what it should show
  function automatic panel_view_t panel_step(fsiac_pkg::item_t ev);
    logic [3:0] limit;
    panel_view_t v;
    if (ev.disarm_held) begin
      panel_reinit();
    end else begin
      if (ev.func == fsiac_pkg::FUNC_PULSE && !ev.guard_off && !panel.intrusion_active) begin
        limit = (levels_now.pulses_to_trip == '0) ? 4'd1 : levels_now.pulses_to_trip;
        panel.pulse_count = panel.pulse_count + 4'd1;
        if (panel.pulse_count >= limit) begin
          panel.latches[fsiac_pkg::B_ALARM] = 1'b1;
          panel.latches[fsiac_pkg::B_LIGHT] = 1'b1;
          panel.intrusion_active = 1'b1;
          panel.pulse_count = '0;
          refresh_leds();
        end
      end else if (ev.func == fsiac_pkg::FUNC_TICK && panel.sampler_running) begin
        limit = (levels_now.ticks_per_sample == '0) ? 4'd1 : levels_now.ticks_per_sample;
        panel.tick_count = panel.tick_count + 4'd1;
        if (panel.tick_count >= limit) begin
          panel.sample_pending = 1'b1;
          panel.tick_count = '0;
        end
      end
      if (panel.sample_pending) begin
        panel.sample_pending = 1'b0;
        panel.sampler_running = 1'b1;
        sample_sensors(ev.temp_sample, ev.smoke_sample);
      end
      if (!ev.guard_off) begin
        panel.latches[fsiac_pkg::B_GUARDLED] = 1'b1;
      end else begin
        panel.latches[fsiac_pkg::B_GUARDLED] = 1'b0;
        if (panel.intrusion_active) begin
          panel_reinit();
          panel.intrusion_active = 1'b0;
        end
      end
    end
    v.latches = panel.latches;
    v.temp = panel.temp_latched;
    v.smoke = panel.smoke_latched;
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic script_row_t row(logic [1:0] f, logic d, logic g, logic [7:0] t,
                                      logic [7:0] s, int unsigned reps, bit typed,
                                      logic [fsiac_pkg::NUM_LATCH-1:0] l,
                                      logic [8:0] tv, logic [6:0] sv);
    script_row_t r;
    r.ev.func = f;
    r.ev.disarm_held = d;
    r.ev.guard_off = g;
    r.ev.temp_sample = t;
    r.ev.smoke_sample = s;
    r.reps = reps;
    r.typed = typed;
    r.want.latches = l;
    r.want.temp = tv;
    r.want.smoke = sv;
    return r;
  endfunction

  function automatic fsiac_pkg::cfg_t levels(int unsigned fon, int unsigned foff,
                                             int unsigned son, int unsigned soff,
                                             int unsigned pulses, int unsigned ticks);
    fsiac_pkg::cfg_t c;
    c.fire_on_level = 9'(fon);
    c.fire_off_level = 9'(foff);
    c.smoke_on_level = 7'(son);
    c.smoke_off_level = 7'(soff);
    c.pulses_to_trip = 4'(pulses);
    c.ticks_per_sample = 4'(ticks);
    return c;
  endfunction

  // Mostly armed and guarded events with pulse trains and ticks; some noise
  function automatic fsiac_pkg::item_t random_event();
    fsiac_pkg::item_t ev;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) ev.func = fsiac_pkg::FUNC_TICK;
    else if (pick < 78) ev.func = fsiac_pkg::FUNC_PULSE;
    else if (pick < 95) ev.func = fsiac_pkg::FUNC_POLL;
    else ev.func = FUNC_SPARE;
    ev.disarm_held = ($urandom_range(0, 29) == 0);
    ev.guard_off = ($urandom_range(0, 11) == 0);
    ev.temp_sample = 8'($urandom_range(0, 255));
    ev.smoke_sample = 8'($urandom_range(0, 255));
    return ev;
  endfunction

  // Offer one event, hold it until accepted, then record its expected view
  task automatic offer(input fsiac_pkg::item_t ev, input bit typed,
                       input panel_view_t typed_want);
    panel_view_t want;
    in_valid <= 1'b1;
    func <= ev.func;
    disarm_held <= ev.disarm_held;
    guard_off <= ev.guard_off;
    temp_sample <= ev.temp_sample;
    smoke_sample <= ev.smoke_sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = panel_step(ev);
    expected_views.push_back(typed ? typed_want : want);
    accepted_events++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic random_burst(input int unsigned count);
    panel_view_t unused;
    unused = '0;
    repeat (count) begin
      offer(random_event(), 1'b0, unused);
      sender_gap();
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_all_results();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_views.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Write all six thresholds while the panel is idle
  task automatic program_levels(input fsiac_pkg::cfg_t c);
    cfg_idx_t idx;
    cfg_word_t data;
    for (int k = fsiac_pkg::REG_FIRE_ON; k <= fsiac_pkg::REG_TICKS; k++) begin
      idx = cfg_idx_t'(k);
      case (idx)
        fsiac_pkg::REG_FIRE_ON:   data = c.fire_on_level;
        fsiac_pkg::REG_FIRE_OFF:  data = cfg_word_t'(c.fire_off_level);
        fsiac_pkg::REG_SMOKE_ON:  data = cfg_word_t'(c.smoke_on_level);
        fsiac_pkg::REG_SMOKE_OFF: data = cfg_word_t'(c.smoke_off_level);
        fsiac_pkg::REG_PULSES:    data = cfg_word_t'(c.pulses_to_trip);
        default:                  data = cfg_word_t'(c.ticks_per_sample);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    levels_now = c;
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin
    fsiac_pkg::cfg_t plan [NUM_PLANS];
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= fsiac_pkg::FUNC_POLL;
    disarm_held <= 1'b0;
    guard_off <= 1'b0;
    temp_sample <= '0;
    smoke_sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= fsiac_pkg::REG_FIRE_ON;
    cfg_data <= '0;

    // Predictor starts from the reset state
    panel = '0;
    panel.sample_pending = 1'b1;
    levels_now = levels(fsiac_pkg::FIRE_ON_RST, fsiac_pkg::FIRE_OFF_RST,
                        fsiac_pkg::SMOKE_ON_RST, fsiac_pkg::SMOKE_OFF_RST,
                        fsiac_pkg::PULSES_RST, fsiac_pkg::TICKS_RST);

    // First sample right after reset, tick-driven sample at full scale,
    // disarm, stopped tick, pulse counting to trip, guard off with intrusion
    script[0]  = row(fsiac_pkg::FUNC_POLL, 0, 0, 8'd0, 8'd0, 1, 1,
                     (10'd1 << fsiac_pkg::B_NORMAL) | (10'd1 << fsiac_pkg::B_GUARDLED),
                     9'd0, 7'd0);
    script[1]  = row(fsiac_pkg::FUNC_TICK, 0, 0, 8'd255, 8'd255, 5, 0, '0, '0, '0);
    script[2]  = row(fsiac_pkg::FUNC_TICK, 0, 0, 8'd255, 8'd255, 1, 1,
                     (10'd1 << fsiac_pkg::B_ALARM) | (10'd1 << fsiac_pkg::B_EXHAUST) |
                     (10'd1 << fsiac_pkg::B_EMERG) | (10'd1 << fsiac_pkg::B_SIREN) |
                     (10'd1 << fsiac_pkg::B_FIRELED) | (10'd1 << fsiac_pkg::B_SMOKELED) |
                     (10'd1 << fsiac_pkg::B_GUARDLED), 9'd500, 7'd100);
    script[3]  = row(fsiac_pkg::FUNC_POLL, 1, 0, 8'd0, 8'd0, 1, 1, '0, 9'd500, 7'd100);
    script[4]  = row(fsiac_pkg::FUNC_TICK, 0, 0, 8'd128, 8'd128, 1, 0, '0, '0, '0);
    script[5]  = row(fsiac_pkg::FUNC_PULSE, 0, 1, 8'd0, 8'd0, 1, 0, '0, '0, '0);
    script[6]  = row(fsiac_pkg::FUNC_PULSE, 0, 0, 8'd64, 8'd64, 9, 0, '0, '0, '0);
    script[7]  = row(fsiac_pkg::FUNC_PULSE, 0, 0, 8'd64, 8'd64, 1, 0, '0, '0, '0);
    script[8]  = row(fsiac_pkg::FUNC_PULSE, 0, 0, 8'd64, 8'd64, 1, 0, '0, '0, '0);
    script[9]  = row(FUNC_SPARE, 0, 0, 8'd200, 8'd10, 1, 0, '0, '0, '0);
    script[10] = row(fsiac_pkg::FUNC_POLL, 0, 1, 8'd200, 8'd10, 1, 0, '0, '0, '0);
    script[11] = row(fsiac_pkg::FUNC_POLL, 0, 0, 8'd0, 8'd255, 1, 0, '0, '0, '0);
    script[12] = row(fsiac_pkg::FUNC_PULSE, 1, 0, 8'd0, 8'd0, 1, 0, '0, '0, '0);
    script[13] = row(fsiac_pkg::FUNC_TICK, 0, 0, 8'd255, 8'd0, 1, 0, '0, '0, '0);

    // Zero thresholds, width maxima, range maxima, overlapping bands,
    // a random setting and a typical one
    plan[0] = levels(0, 0, 0, 0, 0, 0);
    plan[1] = levels(511, 511, 127, 127, 15, 15);
    plan[2] = levels(500, 500, 100, 100, 1, 1);
    plan[3] = levels(0, 500, 0, 100, 2, 1);
    plan[4] = levels($urandom_range(0, 511), $urandom_range(0, 511),
                     $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 15), $urandom_range(0, 15));
    plan[5] = levels(300, 100, 50, 20, 4, 2);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      for (int r = 0; r < script[k].reps; r++) begin
        offer(script[k].ev, script[k].typed, script[k].want);
        sender_gap();
      end
    end
    random_burst(EVENTS_PER_PHASE);

    for (int p = 0; p < NUM_PLANS; p++) begin
      wait_all_results();
      program_levels(plan[p]);
      if (p == NUM_PLANS - 1) calm = 1'b1;
      random_burst(EVENTS_PER_PHASE);
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (expected_views.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_views.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS fire_smoke_intrusion_alarm_control");
    end else begin
      $display("FAIL fire_smoke_intrusion_alarm_control");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // Random stalls, one long hold-off to back up the input, none when calm
  initial begin
    bit held_long;
    held_long = 1'b0;
    forever begin
      if (!calm && !held_long && accepted_events >= 300) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_long = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    panel_view_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen.latches = {guard_led, smoke_led, fire_led, intruder_led, normal_led,
                      siren_out, emergency_out, exhaust_out, light_out, alarm_out};
      seen.temp = temperature_shown;
      seen.smoke = smoke_shown;
      if (expected_views.size() == 0) begin
        $display("%0t: result transaction with no event outstanding", $time);
        error_count++;
      end else begin
        want = expected_views.pop_front();
        for (int b = 0; b < fsiac_pkg::NUM_LATCH; b++) begin
          if (seen.latches[b] !== want.latches[b]) begin
            $display("%0t: %s expected %0d got %0d", $time, latch_name[b],
                     want.latches[b], seen.latches[b]);
            error_count++;
          end
        end
        if (seen.temp !== want.temp) begin
          $display("%0t: temperature_shown expected %0d got %0d", $time,
                   want.temp, seen.temp);
          error_count++;
        end
        if (seen.smoke !== want.smoke) begin
          $display("%0t: smoke_shown expected %0d got %0d", $time,
                   want.smoke, seen.smoke);
          error_count++;
        end
      end
    end
  end

  // Hard stop if the handshakes hang
  initial begin
    #2000000;
    $display("FAIL fire_smoke_intrusion_alarm_control");
    $finish;
  end

endmodule
